// ===== sv/tsop_pkg.sv =====
// Package for the TCP SYN option parser: transaction payload types and option codes.
// It has no dependencies. Every module of the parser imports it.
package tsop_pkg;

  // One input transaction: one byte of the option area plus its framing marks.
  typedef struct packed {
    logic [7:0] opt_byte;
    logic       byte_valid;
    logic       first_byte;
    logic       last_byte;
    logic [7:0] tcp_flags;
  } tsop_in_t;

  // One result transaction, given once per option area.
  typedef struct packed {
    logic [31:0] timestamp_value;
    logic [3:0]  window_scale;
    logic        timestamp_ok;
    logic        window_scale_ok;
    logic        sack_ok;
    logic        ecn_ok;
  } tsop_out_t;

  // Option kinds and the lengths that are recorded.
  localparam logic [7:0] KIND_EOL       = 8'd0;
  localparam logic [7:0] KIND_NOP       = 8'd1;
  localparam logic [7:0] KIND_WSCALE    = 8'd3;
  localparam logic [7:0] KIND_SACK_PERM = 8'd4;
  localparam logic [7:0] KIND_TSTAMP    = 8'd8;

  localparam logic [7:0] LEN_MIN        = 8'd2;
  localparam logic [7:0] LEN_SACK_PERM  = 8'd2;
  localparam logic [7:0] LEN_WSCALE     = 8'd3;
  localparam logic [7:0] LEN_TSTAMP     = 8'd10;

  // Data bytes of the timestamp value sit at option positions 2 through 5.
  localparam logic [7:0] TS_VALUE_LAST_POS = 8'd5;
  // First data byte of any option.
  localparam logic [7:0] DATA_FIRST_POS    = 8'd2;

  localparam logic [3:0] MAX_WSCALE     = 4'd14;
  localparam logic [7:0] ECN_FLAGS_MASK = 8'hC0;

  // Bit positions in the found vector.
  localparam int unsigned FOUND_TS   = 0;
  localparam int unsigned FOUND_WS   = 1;
  localparam int unsigned FOUND_SACK = 2;
  localparam int unsigned FOUND_ECN  = 3;

endpackage

// ===== sv/tcp_syn_option_parser_top.sv =====
// Top level of the TCP SYN option parser: input register, option walker, result register.
// Depends on tsop_pkg, tsop_in_stage, tsop_walker and tsop_out_stage.
//
//   Channel  Direction  Handshake                 Payload
//   in       input      in_valid_i / in_stall_o   in_data_i  (tsop_in_t, one option byte)
//   out      output     out_valid_o / out_stall_i out_data_o (tsop_out_t, one per area)
//
// Each input transaction is registered, walked through the option state and, on the area's
// last byte, written to the result register, so a result passes the input register and then
// the result register before it is offered on out. One byte is accepted every cycle; the only
// thing that holds the input back is a last byte that finds the result register still full
// and stalled.
// Reset clears the per-header state, both valid flags and every running counter.
// Output stall propagates combinationally to in_stall_o through the input register.
module tcp_syn_option_parser_top
  import tsop_pkg::*;
#(
  parameter int unsigned MAX_OPTION_STEPS = 10,
  parameter int unsigned MAX_AREA_BYTES   = 40
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  tsop_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output tsop_out_t out_data_o
);

  logic      item_valid;
  tsop_in_t  item;
  logic      take;
  logic      out_free;
  logic      res_valid;
  tsop_out_t res;

  // A byte that ends the area needs room in the result register; any other byte moves on.
  assign take = item_valid && (!item.last_byte || out_free);

  tsop_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_data_i    (in_data_i),
    .take_i       (take),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  tsop_walker #(
    .MAX_OPTION_STEPS (MAX_OPTION_STEPS),
    .MAX_AREA_BYTES   (MAX_AREA_BYTES)
  ) u_walker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .take_i      (take),
    .item_i      (item),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  tsop_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // A new result only follows a consumed last byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(item_valid && item.last_byte))
    else $error("result appeared without a last byte");

  // Values are zero unless their option was committed, and the scale is clamped.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.timestamp_ok |-> out_data_o.timestamp_value == '0)
    else $error("timestamp value without timestamp option");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.window_scale <= MAX_WSCALE) &&
                    (out_data_o.window_scale_ok || out_data_o.window_scale == '0))
    else $error("window scale out of range or not committed");

endmodule

// ===== sv/tsop_in_stage.sv =====
// Input register of the TCP SYN option parser.
// It holds one accepted input transaction until the option walker consumes it. Uses tsop_pkg.
module tsop_in_stage
  import tsop_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  tsop_in_t in_data_i,
  input  logic     take_i,
  output logic     item_valid_o,
  output tsop_in_t item_o
);

  logic     valid_q;
  logic     valid_d;
  tsop_in_t data_q;
  logic     load;

  // The register can be refilled in the same cycle that its content is consumed.
  assign in_stall_o = valid_q && !take_i;
  assign load       = in_valid_i && !in_stall_o;
  assign valid_d    = load || (valid_q && !take_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= in_data_i;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = data_q;

endmodule

// ===== sv/tsop_walker.sv =====
// Option walker of the TCP SYN option parser: per-header running state and its update.
// It takes one byte per consumed transaction and forms the result on the last byte. Uses tsop_pkg.
module tsop_walker
  import tsop_pkg::*;
#(
  parameter int unsigned MAX_OPTION_STEPS = 10,
  parameter int unsigned MAX_AREA_BYTES   = 40
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      take_i,
  input  tsop_in_t  item_i,
  output logic      res_valid_o,
  output tsop_out_t res_o
);

  localparam int unsigned AW = $clog2(MAX_AREA_BYTES + 1);
  localparam int unsigned SW = $clog2(MAX_OPTION_STEPS + 1);

  logic [AW-1:0] offset_q,   offset_d;
  logic [7:0]    kind_q,     kind_d;
  logic [7:0]    length_q,   length_d;
  logic [AW-1:0] position_q, position_d;
  logic [SW-1:0] steps_q,    steps_d;
  logic          stopped_q,  stopped_d;
  logic [31:0]   pending_q,  pending_d;
  logic [31:0]   kept_ts_q,  kept_ts_d;
  logic [3:0]    kept_ws_q,  kept_ws_d;
  logic [3:0]    found_q,    found_d;

  // State after this transaction's byte, before the end-of-area clear.
  logic [AW-1:0] offset_n;
  logic [7:0]    kind_n;
  logic [7:0]    length_n;
  logic [AW-1:0] position_n;
  logic [SW-1:0] steps_n;
  logic          stopped_n;
  logic [31:0]   pending_n;
  logic [31:0]   kept_ts_n;
  logic [3:0]    kept_ws_n;
  logic [3:0]    found_n;

  always_comb begin
    logic [7:0]    b;
    logic [8:0]    end_sum;
    logic [AW-1:0] pos_inc;
    logic          is_ts;
    logic          is_ws;

    b = item_i.opt_byte;

    // A first mark starts from a cleared header and samples the flags.
    if (item_i.first_byte) begin
      offset_n   = '0;
      kind_n     = '0;
      length_n   = '0;
      position_n = '0;
      steps_n    = '0;
      stopped_n  = 1'b0;
      pending_n  = '0;
      kept_ts_n  = '0;
      kept_ws_n  = '0;
      found_n    = '0;
      found_n[FOUND_ECN] = (item_i.tcp_flags & ECN_FLAGS_MASK) == ECN_FLAGS_MASK;
    end else begin
      offset_n   = offset_q;
      kind_n     = kind_q;
      length_n   = length_q;
      position_n = position_q;
      steps_n    = steps_q;
      stopped_n  = stopped_q;
      pending_n  = pending_q;
      kept_ts_n  = kept_ts_q;
      kept_ws_n  = kept_ws_q;
      found_n    = found_q;
    end

    is_ts   = (kind_n == KIND_TSTAMP) && (length_n == LEN_TSTAMP);
    is_ws   = (kind_n == KIND_WSCALE) && (length_n == LEN_WSCALE);
    end_sum = 9'(offset_n - AW'(1)) + 9'(b);
    pos_inc = position_n + AW'(1);

    if (item_i.byte_valid && !stopped_n) begin
      if (offset_n >= AW'(MAX_AREA_BYTES)) begin
        stopped_n = 1'b1;
      end else begin
        if (position_n == '0) begin
          // Kind byte.
          if (steps_n >= SW'(MAX_OPTION_STEPS) || b == KIND_EOL) begin
            stopped_n = 1'b1;
          end else begin
            steps_n = steps_n + SW'(1);
            if (b != KIND_NOP) begin
              kind_n     = b;
              position_n = AW'(1);
              pending_n  = '0;
            end
          end
        end else if (position_n == AW'(1)) begin
          // Length byte: the whole option must fit in the area.
          if (b < LEN_MIN || end_sum > 9'(MAX_AREA_BYTES)) begin
            stopped_n = 1'b1;
          end else begin
            length_n = b;
            if (b == LEN_SACK_PERM) begin
              if (kind_n == KIND_SACK_PERM) begin
                found_n[FOUND_SACK] = 1'b1;
              end
              position_n = '0;
            end else begin
              position_n = AW'(DATA_FIRST_POS);
            end
          end
        end else begin
          // Data byte.
          if (is_ts && 8'(position_n) <= TS_VALUE_LAST_POS) begin
            pending_n = {pending_n[23:0], b};
          end else if (is_ws && 8'(position_n) == DATA_FIRST_POS) begin
            pending_n = 32'(b);
          end
          position_n = pos_inc;
          if (8'(pos_inc) >= length_n) begin
            if (is_ws) begin
              kept_ws_n = (pending_n > 32'(MAX_WSCALE)) ? MAX_WSCALE : pending_n[3:0];
              found_n[FOUND_WS] = 1'b1;
            end else if (is_ts) begin
              kept_ts_n = pending_n;
              found_n[FOUND_TS] = 1'b1;
            end
            position_n = '0;
            pending_n  = '0;
          end
        end
        offset_n = offset_n + AW'(1);
      end
    end
  end

  // The result reflects the state after this byte; then the header is cleared.
  always_comb begin
    res_valid_o           = take_i && item_i.last_byte;
    res_o.timestamp_value = found_n[FOUND_TS] ? kept_ts_n : '0;
    res_o.window_scale    = found_n[FOUND_WS] ? kept_ws_n : '0;
    res_o.timestamp_ok    = found_n[FOUND_TS];
    res_o.window_scale_ok = found_n[FOUND_WS];
    res_o.sack_ok         = found_n[FOUND_SACK];
    res_o.ecn_ok          = found_n[FOUND_ECN];
  end

  always_comb begin
    offset_d   = offset_q;
    kind_d     = kind_q;
    length_d   = length_q;
    position_d = position_q;
    steps_d    = steps_q;
    stopped_d  = stopped_q;
    pending_d  = pending_q;
    kept_ts_d  = kept_ts_q;
    kept_ws_d  = kept_ws_q;
    found_d    = found_q;
    if (take_i) begin
      if (item_i.last_byte) begin
        offset_d   = '0;
        kind_d     = '0;
        length_d   = '0;
        position_d = '0;
        steps_d    = '0;
        stopped_d  = 1'b0;
        pending_d  = '0;
        kept_ts_d  = '0;
        kept_ws_d  = '0;
        found_d    = '0;
      end else begin
        offset_d   = offset_n;
        kind_d     = kind_n;
        length_d   = length_n;
        position_d = position_n;
        steps_d    = steps_n;
        stopped_d  = stopped_n;
        pending_d  = pending_n;
        kept_ts_d  = kept_ts_n;
        kept_ws_d  = kept_ws_n;
        found_d    = found_n;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q   <= '0;
      kind_q     <= '0;
      length_q   <= '0;
      position_q <= '0;
      steps_q    <= '0;
      stopped_q  <= 1'b0;
      pending_q  <= '0;
      kept_ts_q  <= '0;
      kept_ws_q  <= '0;
      found_q    <= '0;
    end else begin
      offset_q   <= offset_d;
      kind_q     <= kind_d;
      length_q   <= length_d;
      position_q <= position_d;
      steps_q    <= steps_d;
      stopped_q  <= stopped_d;
      pending_q  <= pending_d;
      kept_ts_q  <= kept_ts_d;
      kept_ws_q  <= kept_ws_d;
      found_q    <= found_d;
    end
  end

endmodule

// ===== sv/tsop_out_stage.sv =====
// Result register of the TCP SYN option parser.
// It holds one result transaction until the downstream side takes it. Uses tsop_pkg.
module tsop_out_stage
  import tsop_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      res_valid_i,
  input  tsop_out_t res_i,
  output logic      free_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output tsop_out_t out_data_o
);

  logic      valid_q;
  logic      valid_d;
  tsop_out_t data_q;

  // The register is free when empty or when its result leaves this cycle.
  assign free_o  = !valid_q || !out_stall_i;
  assign valid_d = res_valid_i || (valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid_i) begin
      data_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule
